// ===== sv/bsii_pkg.sv =====
// Shared types and constants for the box-sum integral image block.
// No dependencies; imported by the top, load and query modules of the block.
`default_nettype none

package bsii_pkg;

  localparam int SUM_BITS = 28;
  localparam int SIZE_W   = 7;
  localparam int RAD_W    = 6;
  localparam int POS_W    = 6;
  localparam int CFG_W    = 2;

  typedef logic [CFG_W-1:0]    cfg_idx_t;
  typedef logic [SIZE_W-1:0]   size_t;
  typedef logic [RAD_W-1:0]    rad_t;
  typedef logic [POS_W-1:0]    pos_t;
  typedef logic [SUM_BITS-1:0] sum_t;

  localparam cfg_idx_t CFG_ROW_COUNT = 2'd0;
  localparam cfg_idx_t CFG_COL_COUNT = 2'd1;
  localparam cfg_idx_t CFG_RADIUS    = 2'd2;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  localparam size_t ROW_COUNT_RST = 7'd64;
  localparam size_t COL_COUNT_RST = 7'd64;
  localparam rad_t  RADIUS_RST    = 6'd1;

  typedef struct packed {
    logic wr_en;
    logic done;
  } load_stat_t;

  typedef struct packed {
    logic busy;
    logic port;
  } qry_stat_t;

endpackage

`default_nettype wire

// ===== sv/box_sum_integral_image.sv =====
// Load: a read of the entry above in the accepting cycle, then a write, no result;
// no request is taken during the write; a load on a complete table is dropped.
// Query: two pairs of reads on the dual-port table RAM, the first in the accepting
// cycle, the second in rd2 (no request is taken then); result and done register on fin.
// The receiver cannot stall results. Reset: row_count 64, col_count 64, radius 1,
// load position and row sum cleared; table contents stay undefined, no clearing pass.
`default_nettype none

module box_sum_integral_image import bsii_pkg::*; #(
  parameter int MAX_ROWS   = 64,
  parameter int MAX_COLS   = 64,
  parameter int VALUE_BITS = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic                         req_type,
  input  wire logic signed [VALUE_BITS-1:0] element_value,
  input  wire pos_t                         query_row,
  input  wire pos_t                         query_col,
  output logic                              done,
  output logic signed [SUM_BITS-1:0]        block_sum,
  output logic                              status,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire cfg_idx_t                     cfg_index,
  input  wire size_t                        cfg_data
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  size_t      row_count;
  size_t      col_count;
  rad_t       radius;
  size_t      rows, cols;
  logic       cfg_wr, restart, accept, start_l, start_q;
  load_stat_t lstat;
  qry_stat_t  qstat;
  logic [AW-1:0] l_rd_addr, l_wr_addr, q_addr_a, q_addr_b, addr_a;
  sum_t       l_wr_data, rdata_a, rdata_b;

  assign cfg_ready = !busy;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign restart   = cfg_wr && (cfg_index inside {CFG_ROW_COUNT, CFG_COL_COUNT});
  assign busy      = lstat.wr_en || qstat.busy;
  assign accept    = start && !busy;
  assign start_l   = accept && (req_type == REQ_LOAD);
  assign start_q   = accept && (req_type == REQ_QUERY);

  always_comb begin
    if (row_count == '0) begin
      rows = 7'd1;
    end else if (int'(row_count) > MAX_ROWS) begin
      rows = SIZE_W'(MAX_ROWS);
    end else begin
      rows = row_count;
    end
    if (col_count == '0) begin
      cols = 7'd1;
    end else if (int'(col_count) > MAX_COLS) begin
      cols = SIZE_W'(MAX_COLS);
    end else begin
      cols = col_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= ROW_COUNT_RST;
      col_count <= COL_COUNT_RST;
      radius    <= RADIUS_RST;
    end else if (cfg_wr) begin
      case (cfg_index)
        CFG_ROW_COUNT: row_count <= cfg_data;
        CFG_COL_COUNT: col_count <= cfg_data;
        CFG_RADIUS:    radius    <= cfg_data[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  assign addr_a = lstat.wr_en ? l_wr_addr : (qstat.port ? q_addr_a : l_rd_addr);

  bsii_ram #(.WIDTH(SUM_BITS), .DEPTH(DEPTH)) u_table (
    .clk     (clk),
    .we_a    (lstat.wr_en),
    .addr_a  (addr_a),
    .wdata_a (l_wr_data),
    .rdata_a (rdata_a),
    .addr_b  (q_addr_b),
    .rdata_b (rdata_b)
  );

  bsii_load #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS), .VALUE_BITS(VALUE_BITS)) u_load (
    .clk           (clk),
    .rst           (rst),
    .restart       (restart),
    .start_l       (start_l),
    .element_value (element_value),
    .rows          (rows),
    .cols          (cols),
    .rdata         (rdata_a),
    .rd_addr       (l_rd_addr),
    .wr_addr       (l_wr_addr),
    .wr_data       (l_wr_data),
    .stat          (lstat)
  );

  bsii_query #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_query (
    .clk       (clk),
    .rst       (rst),
    .start_q   (start_q),
    .query_row (query_row),
    .query_col (query_col),
    .rows      (rows),
    .cols      (cols),
    .radius    (radius),
    .load_done (lstat.done),
    .rdata_a   (rdata_a),
    .rdata_b   (rdata_b),
    .addr_a    (q_addr_a),
    .addr_b    (q_addr_b),
    .stat      (qstat),
    .done      (done),
    .block_sum (block_sum),
    .status    (status)
  );

  a_no_port_clash: assert property (@(posedge clk) disable iff (rst)
    !(lstat.wr_en && qstat.busy))
    else $error("table write overlaps query read");

  a_query_result: assert property (@(posedge clk) disable iff (rst)
    start_q |-> ##3 done)
    else $error("query request produced no result");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start_q, 3))
    else $error("result without a query request");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status == STATUS_ERR) |-> block_sum == '0)
    else $error("error result carries a nonzero sum");

  a_done_hold: assert property (@(posedge clk) disable iff (rst)
    $fell(lstat.done) |-> $past(restart))
    else $error("load completion dropped without a size write");

endmodule

`default_nettype wire

// ===== sv/bsii_ram.sv =====
// Generic synchronous RAM: port A read/write, port B read only, registered reads.
// No dependencies.
`default_nettype none

module bsii_ram #(
  parameter int WIDTH = 28,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we_a,
  input  wire logic [AW-1:0]    addr_a,
  input  wire logic [WIDTH-1:0] wdata_a,
  output logic      [WIDTH-1:0] rdata_a,
  input  wire logic [AW-1:0]    addr_b,
  output logic      [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we_a) begin
      mem[addr_a] <= wdata_a;
    end
    rdata_a <= mem[addr_a];
    rdata_b <= mem[addr_b];
  end

endmodule

`default_nettype wire

// ===== sv/bsii_load.sv =====
// Load sequencer: raster position, running row sum and table entry update.
// Depends on bsii_pkg; reads the entry above through RAM port A, then writes.
`default_nettype none

module bsii_load import bsii_pkg::*; #(
  parameter int MAX_ROWS   = 64,
  parameter int MAX_COLS   = 64,
  parameter int VALUE_BITS = 16,
  localparam int DEPTH = MAX_ROWS * MAX_COLS,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         restart,
  input  wire logic                         start_l,
  input  wire logic signed [VALUE_BITS-1:0] element_value,
  input  wire size_t                        rows,
  input  wire size_t                        cols,
  input  wire sum_t                         rdata,
  output logic [AW-1:0]                     rd_addr,
  output logic [AW-1:0]                     wr_addr,
  output sum_t                              wr_data,
  output load_stat_t                        stat
);

  localparam int RI_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CI_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  logic [RI_W-1:0]               load_row;
  logic [CI_W-1:0]               load_col;
  sum_t                          row_sum;
  logic                          load_done;
  logic                          wr_en;
  logic signed [VALUE_BITS-1:0]  elem;
  logic signed [63:0]            elem_wide;
  sum_t                          sum_next;
  logic [AW-1:0]                 cur_addr;
  logic                          end_col;
  logic                          end_row;

  assign elem_wide = 64'(elem);
  assign sum_next  = row_sum + elem_wide[SUM_BITS-1:0];
  assign cur_addr  = AW'(load_row) * AW'(MAX_COLS) + AW'(load_col);
  assign rd_addr   = cur_addr - AW'(MAX_COLS);
  assign wr_addr   = cur_addr;
  assign wr_data   = sum_next + ((load_row != '0) ? rdata : '0);
  assign end_col   = (int'(load_col) + 1) >= int'(cols);
  assign end_row   = (int'(load_row) + 1) >= int'(rows);

  assign stat.wr_en = wr_en;
  assign stat.done  = load_done;

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      load_row  <= '0;
      load_col  <= '0;
      row_sum   <= '0;
      load_done <= 1'b0;
      wr_en     <= 1'b0;
    end else begin
      wr_en <= start_l && !load_done;
      if (wr_en) begin
        if (end_col) begin
          load_col <= '0;
          row_sum  <= '0;
          if (end_row) begin
            load_done <= 1'b1;
          end else begin
            load_row <= RI_W'(load_row + 1'b1);
          end
        end else begin
          load_col <= CI_W'(load_col + 1'b1);
          row_sum  <= sum_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_l) begin
      elem <= element_value;
    end
  end

endmodule

`default_nettype wire

// ===== sv/bsii_query.sv =====
// Query unit: clips the window, issues two pairs of table reads, combines them.
// Depends on bsii_pkg; uses both RAM read ports, first in the accepting cycle, then in rd2.
`default_nettype none

module bsii_query import bsii_pkg::*; #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64,
  localparam int DEPTH = MAX_ROWS * MAX_COLS,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start_q,
  input  wire pos_t        query_row,
  input  wire pos_t        query_col,
  input  wire size_t       rows,
  input  wire size_t       cols,
  input  wire rad_t        radius,
  input  wire logic        load_done,
  input  wire sum_t        rdata_a,
  input  wire sum_t        rdata_b,
  output logic [AW-1:0]    addr_a,
  output logic [AW-1:0]    addr_b,
  output qry_stat_t        stat,
  output logic             done,
  output logic signed [SUM_BITS-1:0] block_sum,
  output logic             status
);

  function automatic logic [AW-1:0] flat(input size_t r, input size_t c);
    return AW'(r) * AW'(MAX_COLS) + AW'(c);
  endfunction

  logic          rd2;
  logic          fin;
  logic [AW-1:0] addr_a2;
  logic [AW-1:0] addr_b2;
  logic          has_top_q;
  logic          has_left_q;
  logic          err_q;
  sum_t          partial;

  size_t row_hi, col_hi, bot, right;
  pos_t  top_m1, left_m1;
  logic  has_top, has_left, err;

  always_comb begin
    row_hi   = {1'b0, query_row} + {1'b0, radius};
    col_hi   = {1'b0, query_col} + {1'b0, radius};
    bot      = (row_hi > rows - 7'd1) ? rows - 7'd1 : row_hi;
    right    = (col_hi > cols - 7'd1) ? cols - 7'd1 : col_hi;
    has_top  = query_row > radius;
    has_left = query_col > radius;
    top_m1   = query_row - radius - 6'd1;
    left_m1  = query_col - radius - 6'd1;
    err      = !load_done || ({1'b0, query_row} >= rows) || ({1'b0, query_col} >= cols);
  end

  assign addr_a    = rd2 ? addr_a2 : flat(bot, right);
  assign addr_b    = rd2 ? addr_b2 : flat({1'b0, top_m1}, right);
  assign stat.busy = rd2;
  assign stat.port = rd2 || start_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd2  <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      rd2  <= start_q;
      fin  <= rd2;
      done <= fin;
    end
  end

  always_ff @(posedge clk) begin
    if (start_q) begin
      addr_a2    <= flat(bot, {1'b0, left_m1});
      addr_b2    <= flat({1'b0, top_m1}, {1'b0, left_m1});
      has_top_q  <= has_top;
      has_left_q <= has_left;
      err_q      <= err;
    end
    if (rd2) begin
      partial <= rdata_a - (has_top_q ? rdata_b : '0);
    end
    if (fin) begin
      block_sum <= err_q ? '0 : partial - (has_left_q ? rdata_a : '0)
                   + ((has_top_q && has_left_q) ? rdata_b : '0);
      status    <= err_q ? STATUS_ERR : STATUS_OK;
    end
  end

endmodule

`default_nettype wire
